@@ rtl/core/afs_pkg.sv @@
`timescale 1ns / 1ps

package afs_pkg;

    localparam logic [7:0]  SYNC_BYTE     = 8'hFF;
    localparam logic [7:0]  SYNC_MASK     = 8'hF6;
    localparam logic [7:0]  SYNC_MATCH    = 8'hF0;
    localparam int          HDR_LEN       = 7;
    localparam logic [12:0] LEN_HDR       = 13'd7;
    localparam logic [12:0] MIN_LEN_NOCRC = 13'd7;
    localparam logic [12:0] MIN_LEN_CRC   = 13'd9;
    localparam int          QDEPTH        = 8;
    localparam int          QPTR_W        = $clog2(QDEPTH);
    localparam int          QCNT_W        = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_PASS,
        PH_RESCAN
    } t_phase;

    typedef struct packed {
        logic        no_crc;
        logic [1:0]  profile;
        logic [3:0]  rate_index;
        logic [2:0]  channel_config;
        logic [12:0] frame_len;
        logic [1:0]  raw_block_count;
    } t_fields;

    // One queue entry: a single passed byte, or a whole confirmed header.
    typedef struct packed {
        logic                     is_hdr;
        logic [HDR_LEN-1:0][7:0]  bytes;
        logic                     end_f;
        logic                     abort_f;
        t_fields                  fields;
    } t_entry;

    function automatic logic [16:0] rate_hz(input logic [3:0] idx);
        logic [16:0] hz;
        unique case (idx)
            4'd0:    hz = 17'd96000;
            4'd1:    hz = 17'd88200;
            4'd2:    hz = 17'd64000;
            4'd3:    hz = 17'd48000;
            4'd4:    hz = 17'd44100;
            4'd5:    hz = 17'd32000;
            4'd6:    hz = 17'd24000;
            4'd7:    hz = 17'd22050;
            4'd8:    hz = 17'd16000;
            4'd9:    hz = 17'd12000;
            4'd10:   hz = 17'd11025;
            4'd11:   hz = 17'd8000;
            4'd12:   hz = 17'd7350;
            default: hz = 17'd0;
        endcase
        return hz;
    endfunction

endpackage

@@ rtl/core/afs_front.sv @@
`timescale 1ns / 1ps

module afs_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [7:0]        i_in_byte,
    input  logic              i_end_of_buffer,
    input  logic              i_q_full,
    output logic              o_busy,
    output logic              o_q_push,
    output afs_pkg::t_entry   o_q_entry
);
    import afs_pkg::*;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_held, n_held;
    logic [12:0] r_left, n_left;
    t_fields     r_fields, n_fields;
    logic [7:0]  r_hdr [0:5];
    logic [7:0]  r_scan [0:5];
    logic        scan_load, scan_shift;
    logic [2:0]  r_scan_cnt, n_scan_cnt;

    logic        accept;
    logic [7:0]  feed_b;
    logic [2:0]  feed_held;
    logic        hdr_we;
    logic [2:0]  hdr_wi;
    logic        hdr_done;
    t_fields     dec;
    logic [12:0] min_len;
    logic        false_sync;
    t_entry      entry;

    assign o_busy = (r_phase == PH_RESCAN);
    assign accept = i_push && !i_q_full && !o_busy;
    assign feed_b = (r_phase == PH_RESCAN) ? r_scan[0] : i_in_byte;

    // Sync search and header collection for one byte.
    always_comb begin
        feed_held = r_held;
        hdr_we    = 1'b0;
        hdr_wi    = r_held;
        hdr_done  = 1'b0;
        unique case (r_held) inside
            3'd0: begin
                if (feed_b == SYNC_BYTE) begin
                    hdr_we    = 1'b1;
                    hdr_wi    = 3'd0;
                    feed_held = 3'd1;
                end
            end
            3'd1: begin
                if ((feed_b & SYNC_MASK) == SYNC_MATCH) begin
                    hdr_we    = 1'b1;
                    feed_held = 3'd2;
                end else if (feed_b == SYNC_BYTE) begin
                    hdr_we = 1'b1;
                    hdr_wi = 3'd0;
                end else begin
                    feed_held = 3'd0;
                end
            end
            [3'd2:3'd5]: begin
                hdr_we    = 1'b1;
                feed_held = r_held + 3'd1;
            end
            3'd6: begin
                hdr_done  = 1'b1;
                feed_held = 3'd0;
            end
            default: feed_held = 3'd0;
        endcase
    end

    // Header decode; byte six comes straight from the input.
    always_comb begin
        dec.no_crc          = r_hdr[1][0];
        dec.profile         = r_hdr[2][7:6];
        dec.rate_index      = r_hdr[2][5:2];
        dec.channel_config  = {r_hdr[2][0], r_hdr[3][7:6]};
        dec.frame_len       = {r_hdr[3][1:0], r_hdr[4], r_hdr[5][7:5]};
        dec.raw_block_count = i_in_byte[1:0];
        min_len             = dec.no_crc ? MIN_LEN_NOCRC : MIN_LEN_CRC;
        false_sync          = dec.frame_len < min_len;
    end

    always_comb begin
        n_phase    = r_phase;
        n_held     = r_held;
        n_left     = r_left;
        n_fields   = r_fields;
        n_scan_cnt = r_scan_cnt;
        scan_load  = 1'b0;
        scan_shift = 1'b0;
        o_q_push   = 1'b0;
        entry      = '0;

        unique case (r_phase)
            PH_PASS: begin
                if (accept) begin
                    o_q_push       = 1'b1;
                    entry.bytes[0] = i_in_byte;
                    entry.end_f    = (r_left == 13'd1);
                    entry.abort_f  = (r_left != 13'd1) && i_end_of_buffer;
                    entry.fields   = r_fields;
                    n_left         = r_left - 13'd1;
                    if (r_left == 13'd1) begin
                        n_phase = PH_HUNT;
                    end
                end
            end
            PH_RESCAN: begin
                // Refeed held header bytes one a cycle; cannot complete a header.
                scan_shift = 1'b1;
                n_held     = feed_held;
                n_scan_cnt = r_scan_cnt - 3'd1;
                if (r_scan_cnt == 3'd1) begin
                    n_phase = PH_HUNT;
                end
            end
            default: begin
                if (accept) begin
                    n_held = feed_held;
                    if (hdr_done) begin
                        if (false_sync) begin
                            if (!i_end_of_buffer) begin
                                scan_load  = 1'b1;
                                n_scan_cnt = 3'd6;
                                n_phase    = PH_RESCAN;
                            end
                        end else begin
                            o_q_push     = 1'b1;
                            entry.is_hdr = 1'b1;
                            for (int k = 0; k < HDR_LEN - 1; k++) begin
                                entry.bytes[k] = r_hdr[k];
                            end
                            entry.bytes[HDR_LEN-1] = i_in_byte;
                            entry.end_f   = (dec.frame_len == LEN_HDR);
                            entry.abort_f = (dec.frame_len != LEN_HDR) && i_end_of_buffer;
                            entry.fields  = dec;
                            n_fields      = dec;
                            if (dec.frame_len != LEN_HDR) begin
                                n_phase = PH_PASS;
                                n_left  = dec.frame_len - LEN_HDR;
                            end
                        end
                    end
                end
            end
        endcase

        if (accept && i_end_of_buffer) begin
            n_phase = PH_HUNT;
            n_held  = 3'd0;
            n_left  = 13'd0;
        end
    end

    assign o_q_entry = entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_HUNT;
            r_held     <= 3'd0;
            r_left     <= 13'd0;
            r_scan_cnt <= 3'd0;
        end else begin
            r_phase    <= n_phase;
            r_held     <= n_held;
            r_left     <= n_left;
            r_scan_cnt <= n_scan_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fields <= n_fields;
        if ((accept || r_phase == PH_RESCAN) && hdr_we && r_phase != PH_PASS) begin
            r_hdr[hdr_wi] <= feed_b;
        end
        if (scan_load) begin
            for (int k = 0; k < 5; k++) begin
                r_scan[k] <= r_hdr[k+1];
            end
            r_scan[5] <= i_in_byte;
        end else if (scan_shift) begin
            for (int k = 0; k < 5; k++) begin
                r_scan[k] <= r_scan[k+1];
            end
        end
    end

endmodule

@@ rtl/core/afs_fifo.sv @@
`timescale 1ns / 1ps

module afs_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  afs_pkg::t_entry   i_entry,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output afs_pkg::t_entry   o_head
);
    import afs_pkg::*;

    t_entry              r_mem [0:QDEPTH-1];
    logic [QPTR_W-1:0]   r_wr, n_wr;
    logic [QPTR_W-1:0]   r_rd, n_rd;
    logic [QCNT_W-1:0]   r_cnt, n_cnt;
    logic                do_push, do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_head  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = do_push ? r_wr + QPTR_W'(1) : r_wr;
        n_rd  = do_pop  ? r_rd + QPTR_W'(1) : r_rd;
        n_cnt = r_cnt + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

endmodule

@@ rtl/core/afs_back.sv @@
`timescale 1ns / 1ps

module afs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  afs_pkg::t_entry   i_head,
    input  logic              i_q_empty,
    input  logic              i_pop,
    output logic              o_q_pop,
    output logic [7:0]        o_out_byte,
    output logic              o_frame_start,
    output logic              o_frame_end,
    output logic              o_frame_aborted,
    output logic              o_run_last,
    output logic              o_no_crc,
    output logic [1:0]        o_profile,
    output logic [3:0]        o_rate_index,
    output logic [16:0]       o_sample_rate,
    output logic [2:0]        o_channel_config,
    output logic [12:0]       o_frame_len,
    output logic [1:0]        o_raw_block_count
);
    import afs_pkg::*;

    logic [2:0] r_idx, n_idx;
    logic       last;
    logic       take;

    assign last = !i_head.is_hdr || (r_idx == 3'(HDR_LEN - 1));
    assign take = i_pop && !i_q_empty;

    assign o_q_pop           = take && last;
    assign o_out_byte        = i_head.bytes[r_idx];
    assign o_frame_start     = i_head.is_hdr && (r_idx == 3'd0);
    assign o_frame_end       = last && i_head.end_f;
    assign o_frame_aborted   = last && i_head.abort_f;
    assign o_run_last        = last;
    assign o_no_crc          = i_head.fields.no_crc;
    assign o_profile         = i_head.fields.profile;
    assign o_rate_index      = i_head.fields.rate_index;
    assign o_sample_rate     = rate_hz(i_head.fields.rate_index);
    assign o_channel_config  = i_head.fields.channel_config;
    assign o_frame_len       = i_head.fields.frame_len;
    assign o_raw_block_count = i_head.fields.raw_block_count;

    // Step through the seven header bytes; a single byte retires at once.
    always_comb begin
        n_idx = r_idx;
        if (take) begin
            n_idx = last ? 3'd0 : r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
        end else begin
            r_idx <= n_idx;
        end
    end

endmodule

@@ rtl/core/adts_frame_splitter_top.sv @@
`timescale 1ns / 1ps

// ADTS frame splitter: cuts an AAC ADTS byte stream into frames.
// Input channel: push/full. One stream byte per transaction on i_in_byte,
// with i_end_of_buffer marking the last byte of a buffer.
// Result channel: empty/pop. Each transaction carries one frame byte with
// start/end/aborted marks, run_last, and the decoded header fields.
// A front stage hunts for sync, collects the 7-byte header and decodes it;
// an 8-entry queue carries single bytes and whole headers to a back stage
// that plays them out one byte per pop.
// Throughput: one input byte per cycle while full is low. A confirmed header
// yields 7 results over 7 pops, during which the queue absorbs the following
// frame bytes. A false sync (frame length too short) stalls input while the
// front refeeds the held header bytes to the sync search.
// A result is registered in the queue and shows on the output ports in the
// cycle after the transaction that caused it, behind any results already queued.
// Reset (synchronous, active low): queue empties, front returns to hunting.
// When the receiver stalls, the queue fills and full rises; full also rises
// during a false-sync refeed.
module adts_frame_splitter_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_buffer,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_out_byte,
    output logic        o_frame_start,
    output logic        o_frame_end,
    output logic        o_frame_aborted,
    output logic        o_run_last,
    output logic        o_no_crc,
    output logic [1:0]  o_profile,
    output logic [3:0]  o_rate_index,
    output logic [16:0] o_sample_rate,
    output logic [2:0]  o_channel_config,
    output logic [12:0] o_frame_len,
    output logic [1:0]  o_raw_block_count
);
    import afs_pkg::*;

    logic   q_push, q_pop, q_full, q_empty, front_busy;
    t_entry q_entry, q_head;

    // Hold input while the queue is full or the front is refeeding.
    assign full  = q_full || front_busy;
    assign empty = q_empty;

    afs_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_push          (push),
        .i_in_byte       (i_in_byte),
        .i_end_of_buffer (i_end_of_buffer),
        .i_q_full        (q_full),
        .o_busy          (front_busy),
        .o_q_push        (q_push),
        .o_q_entry       (q_entry)
    );

    afs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_head  (q_head)
    );

    afs_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head            (q_head),
        .i_q_empty         (q_empty),
        .i_pop             (pop),
        .o_q_pop           (q_pop),
        .o_out_byte        (o_out_byte),
        .o_frame_start     (o_frame_start),
        .o_frame_end       (o_frame_end),
        .o_frame_aborted   (o_frame_aborted),
        .o_run_last        (o_run_last),
        .o_no_crc          (o_no_crc),
        .o_profile         (o_profile),
        .o_rate_index      (o_rate_index),
        .o_sample_rate     (o_sample_rate),
        .o_channel_config  (o_channel_config),
        .o_frame_len       (o_frame_len),
        .o_raw_block_count (o_raw_block_count)
    );

endmodule

@@ rtl/core/afs_checker.sv @@
`timescale 1ns / 1ps

module afs_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic [7:0]  o_out_byte,
    input logic        o_frame_start,
    input logic        o_frame_end,
    input logic        o_frame_aborted,
    input logic        o_run_last
);

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out_byte) && $stable(o_frame_start)))
        else $error("result changed while stalled");

    // A frame opens on the sync byte and is never its own last result.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_start) |-> (o_out_byte == 8'hFF && !o_run_last && !o_frame_end))
        else $error("bad frame start");

    // A frame cannot both complete and abort.
    a_end_abort: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_frame_end) |-> !o_frame_aborted)
        else $error("frame end and abort together");

    // Header byte one follows a popped frame start.
    a_hdr_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && pop && o_frame_start) |=> (!empty && !o_frame_start))
        else $error("header sequence broken");

endmodule

bind adts_frame_splitter_top afs_checker u_afs_checker (.*);
